// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define UTF8V_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Check a condition in the cycle after a trigger.
`define UTF8V_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed");

// Check a condition in the same cycle as a trigger.
`define UTF8V_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/utf8v_pkg.sv =====
// Shared types, constants and error codes of the UTF-8 BMP decoder.
// No dependencies.
package utf8v_pkg;

	localparam int unsigned CNT_W = 16;
	localparam int unsigned CP_W  = 16;
	localparam int unsigned ERR_W = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NON_BMP   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_STRAY     = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BAD_CONT  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic             char_ready;
		logic [CP_W-1:0]  code_point;
		logic             string_done;
		logic [ERR_W-1:0] error_code;
		logic [CNT_W-1:0] octet_count;
		logic [CNT_W-1:0] char_count;
		logic             has_embedded_nul;
	} out_beat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/core/utf8v_ifs.sv =====
// Valid/ready channel interfaces for the UTF-8 BMP decoder.
// Depends on nothing; payload fields carry their own widths.
interface utf8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8v_out_if;
	logic        valid;
	logic        ready;
	logic        char_ready;
	logic [15:0] code_point;
	logic        string_done;
	logic [2:0]  error_code;
	logic [15:0] octet_count;
	logic [15:0] char_count;
	logic        has_embedded_nul;

	modport source (output valid, output char_ready, output code_point,
		output string_done, output error_code, output octet_count,
		output char_count, output has_embedded_nul, input ready);
	modport sink   (input valid, input char_ready, input code_point,
		input string_done, input error_code, input octet_count,
		input char_count, input has_embedded_nul, output ready);
endinterface

interface utf8v_cfg_if;
	logic valid;
	logic ready;
	logic nul_terminated;

	modport source (output valid, output nul_terminated, input ready);
	modport sink   (input valid, input nul_terminated, output ready);
endinterface

// ===== rtl/core/utf8v_in_stage.sv =====
// Input register stage: captures one byte beat and holds it until decoded.
// Depends on utf8v_pkg and utf8v_in_if.
module utf8v_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	utf8v_in_if.sink          din,
	input  logic              advance,
	output logic              valid_s1,
	output utf8v_pkg::in_beat_t beat_s1
);
	import utf8v_pkg::*;

	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			beat_s1.data_byte     <= din.data_byte;
			beat_s1.end_of_string <= din.end_of_string;
		end
	end

endmodule

// ===== rtl/core/utf8v_decode.sv =====
// Stream state and per-byte decode: lead/continuation checks, counters.
// Depends on utf8v_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8v_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nul_terminated,
	input  logic                 step,
	input  utf8v_pkg::in_beat_t  beat,
	output utf8v_pkg::out_beat_t res
);
	import utf8v_pkg::*;

	logic [1:0]       pend_q, pend_d;
	logic [CP_W-1:0]  part_q, part_d;
	logic [CNT_W-1:0] octet_q, octet_d;
	logic [CNT_W-1:0] char_q, char_d;
	logic             nul_q, nul_d;

	logic [7:0] b;
	logic       last;
	logic       good;
	logic       done;

	assign b    = beat.data_byte;
	assign last = !nul_terminated && beat.end_of_string;
	assign good = (b[7:6] == 2'b10);

	always_comb begin
		pend_d  = pend_q;
		part_d  = part_q;
		octet_d = octet_q;
		char_d  = char_q;
		nul_d   = nul_q;
		res     = '0;
		res.error_code = ERR_NONE;
		done    = 1'b0;

		if (pend_q == 2'd0) begin
			priority if (nul_terminated && b == 8'h00) begin
				done = 1'b1;
			end else if (b[7:4] == 4'hF) begin
				res.error_code = ERR_NON_BMP;
				done = 1'b1;
			end else if (b[7:6] == 2'b10) begin
				res.error_code = ERR_STRAY;
				done = 1'b1;
			end else if (b[7:4] == 4'hE || b[7:5] == 3'b110) begin
				if (last) begin
					res.error_code = ERR_TRUNCATED;
					done = 1'b1;
				end else begin
					octet_d = sat_inc(octet_q);
					if (b[7:4] == 4'hE) begin
						part_d = {b[3:0], 12'h000};
						pend_d = 2'd2;
					end else begin
						part_d = {5'b0, b[4:0], 6'b0};
						pend_d = 2'd1;
					end
				end
			end else begin
				if (b == 8'h00) begin
					nul_d = 1'b1;
				end
				octet_d        = sat_inc(octet_q);
				char_d         = sat_inc(char_q);
				res.char_ready = 1'b1;
				res.code_point = {9'b0, b[6:0]};
				done           = last;
			end
		end else if (pend_q[1]) begin
			priority if (last) begin
				res.error_code = ERR_TRUNCATED;
				done = 1'b1;
			end else if (!good) begin
				res.error_code = ERR_BAD_CONT;
				done = 1'b1;
			end else begin
				octet_d = sat_inc(octet_q);
				part_d  = part_q | {4'b0, b[5:0], 6'b0};
				pend_d  = 2'd1;
			end
		end else begin
			if (!good) begin
				res.error_code = ERR_BAD_CONT;
				done = 1'b1;
			end else begin
				octet_d        = sat_inc(octet_q);
				char_d         = sat_inc(char_q);
				res.char_ready = 1'b1;
				res.code_point = part_q | {10'b0, b[5:0]};
				pend_d         = 2'd0;
				part_d         = '0;
				done           = last;
			end
		end

		res.string_done      = done;
		res.octet_count      = octet_d;
		res.char_count       = char_d;
		res.has_embedded_nul = nul_d;

		if (done) begin
			pend_d  = 2'd0;
			part_d  = '0;
			octet_d = '0;
			char_d  = '0;
			nul_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			part_q  <= '0;
			octet_q <= '0;
			char_q  <= '0;
			nul_q   <= 1'b0;
		end else if (step) begin
			pend_q  <= pend_d;
			part_q  <= part_d;
			octet_q <= octet_d;
			char_q  <= char_d;
			nul_q   <= nul_d;
		end
	end

	`UTF8V_ASSERT_ALWAYS(a_pend_range, pend_q != 2'd3)
	`UTF8V_ASSERT_NEXT(a_done_clears, step && res.string_done,
		pend_q == 2'd0 && octet_q == '0 && char_q == '0 && !nul_q)
	`UTF8V_ASSERT_SAME(a_error_ends, res.error_code != ERR_NONE,
		res.string_done && !res.char_ready)
	`UTF8V_ASSERT_ALWAYS(a_chars_le_octets, char_q <= octet_q)

endmodule

// ===== rtl/core/utf8_bmp_validate_decode_core.sv =====
// Path: input register, combinational decode, then the output register.
// Throughput: one byte per cycle unless the output stalls; the output and input
// registers let a new byte enter while a finished result waits to be taken.
// Reset: arst_n clears stream state, counters, nul_terminated and both valid bits.
// Depends on utf8v_pkg, utf8v_ifs, utf8v_in_stage and utf8v_decode.
module utf8_bmp_validate_decode_core (
	input  logic         clk,
	input  logic         arst_n,
	utf8v_cfg_if.sink    cfg,
	utf8v_in_if.sink     din,
	utf8v_out_if.source  dout
);
	import utf8v_pkg::*;

	logic      nul_term_q;
	logic      valid_s1;
	in_beat_t  beat_s1;
	logic      advance;
	out_beat_t res;
	logic      valid_s2;
	out_beat_t beat_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_term_q <= 1'b0;
		end else if (cfg.valid) begin
			nul_term_q <= cfg.nul_terminated;
		end
	end

	assign advance = valid_s1 && (!valid_s2 || dout.ready);

	utf8v_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	utf8v_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.nul_terminated (nul_term_q),
		.step           (advance),
		.beat           (beat_s1),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || dout.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s2 <= res;
		end
	end

	assign dout.valid            = valid_s2;
	assign dout.char_ready       = beat_s2.char_ready;
	assign dout.code_point       = beat_s2.code_point;
	assign dout.string_done      = beat_s2.string_done;
	assign dout.error_code       = beat_s2.error_code;
	assign dout.octet_count      = beat_s2.octet_count;
	assign dout.char_count       = beat_s2.char_count;
	assign dout.has_embedded_nul = beat_s2.has_embedded_nul;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for utf8_bmp_validate_decode_core: drives octets and mode writes,
// predicts every result beat in-line and compares it field by field against the output.
// Depends on utf8v_pkg, utf8v_ifs and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8v_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	utf8v_cfg_if cfg_bus();
	utf8v_in_if  byte_bus();
	utf8v_out_if result_bus();

	utf8_bmp_validate_decode_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.din    (byte_bus),
		.dout   (result_bus)
	);

	always #5 clk = ~clk;

	// decoder shadow state
	logic             nul_mode;
	logic [1:0]       conts_left;
	logic [CP_W-1:0]  partial_cp;
	logic [CNT_W-1:0] octets_seen;
	logic [CNT_W-1:0] chars_seen;
	logic             nul_flag;

	out_beat_t   expected_q[$];
	int unsigned mismatches = 0;
	int unsigned octets_sent = 0;
	bit          idle_en = 1'b1;
	bit          stall_en = 1'b1;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic void clear_stream();
		conts_left  = 2'd0;
		partial_cp  = '0;
		octets_seen = '0;
		chars_seen  = '0;
		nul_flag    = 1'b0;
	endfunction

	function automatic out_beat_t decode_octet(input logic [7:0] b, input logic eos);
		out_beat_t r;
		logic      last;
		logic      done;
		logic      good;
		r    = '0;
		last = !nul_mode && eos;
		done = 1'b0;
		good = (b[7:6] == 2'b10);
		if (conts_left == 2'd0) begin
			if (nul_mode && b == 8'h00) begin
				done = 1'b1;
			end else if (b[7:4] == 4'hF) begin
				r.error_code = ERR_NON_BMP;
				done = 1'b1;
			end else if (good) begin
				r.error_code = ERR_STRAY;
				done = 1'b1;
			end else if (b[7:4] == 4'hE || b[7:5] == 3'b110) begin
				if (last) begin
					r.error_code = ERR_TRUNCATED;
					done = 1'b1;
				end else begin
					octets_seen = count_up(octets_seen);
					if (b[7:4] == 4'hE) begin
						partial_cp = {b[3:0], 12'h000};
						conts_left = 2'd2;
					end else begin
						partial_cp = {5'b0, b[4:0], 6'b0};
						conts_left = 2'd1;
					end
				end
			end else begin
				if (b == 8'h00)
					nul_flag = 1'b1;
				octets_seen  = count_up(octets_seen);
				chars_seen   = count_up(chars_seen);
				r.char_ready = 1'b1;
				r.code_point = {9'b0, b[6:0]};
				done = last;
			end
		end else if (conts_left == 2'd2) begin
			if (last) begin
				r.error_code = ERR_TRUNCATED;
				done = 1'b1;
			end else if (!good) begin
				r.error_code = ERR_BAD_CONT;
				done = 1'b1;
			end else begin
				octets_seen = count_up(octets_seen);
				partial_cp  = partial_cp | {4'b0, b[5:0], 6'b0};
				conts_left  = 2'd1;
			end
		end else begin
			if (!good) begin
				r.error_code = ERR_BAD_CONT;
				done = 1'b1;
			end else begin
				octets_seen  = count_up(octets_seen);
				chars_seen   = count_up(chars_seen);
				r.char_ready = 1'b1;
				r.code_point = partial_cp | {10'b0, b[5:0]};
				conts_left   = 2'd0;
				partial_cp   = '0;
				done = last;
			end
		end
		r.string_done      = done;
		r.octet_count      = octets_seen;
		r.char_count       = chars_seen;
		r.has_embedded_nul = nul_flag;
		if (done)
			clear_stream();
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_octet(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			byte_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_bus.valid         <= 1'b1;
		byte_bus.data_byte     <= b;
		byte_bus.end_of_string <= eos;
		@(posedge clk);
		while (!byte_bus.ready) @(posedge clk);
		expected_q.push_back(decode_octet(b, eos));
		octets_sent++;
	endtask

	task automatic set_mode(input logic m);
		byte_bus.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		cfg_bus.valid          <= 1'b1;
		cfg_bus.nul_terminated <= m;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		nul_mode = m;
	endtask

	task automatic test_length_delimited_forms();
		set_mode(1'b0);
		send_octet(8'h41, 1'b1);
		send_octet(8'h00, 1'b0);
		send_octet(8'h7F, 1'b1);
		send_octet(8'hC2, 1'b0);
		send_octet(8'hA9, 1'b1);
		send_octet(8'hE2, 1'b0);
		send_octet(8'h82, 1'b0);
		send_octet(8'hAC, 1'b1);
		send_octet(8'hEF, 1'b0);
		send_octet(8'hBF, 1'b0);
		send_octet(8'hBF, 1'b1);
		// overlong zero, then an encoded surrogate
		send_octet(8'hC0, 1'b0);
		send_octet(8'h80, 1'b1);
		send_octet(8'hED, 1'b0);
		send_octet(8'hA0, 1'b0);
		send_octet(8'h80, 1'b1);
		send_octet(8'hFF, 1'b0);
		send_octet(8'h80, 1'b0);
		send_octet(8'hC3, 1'b1);
		// truncation wins over a bad first continuation
		send_octet(8'hE1, 1'b0);
		send_octet(8'h41, 1'b1);
		send_octet(8'hE1, 1'b0);
		send_octet(8'h80, 1'b1);
	endtask

	task automatic test_nul_terminated_forms();
		set_mode(1'b1);
		send_octet(8'h48, 1'b0);
		send_octet(8'h00, 1'b1);
		send_octet(8'hE2, 1'b0);
		send_octet(8'h00, 1'b0);
		send_octet(8'hC3, 1'b1);
		send_octet(8'hA9, 1'b1);
		send_octet(8'h00, 1'b0);
		send_octet(8'hF0, 1'b0);
	endtask

	task automatic send_random_string(input logic m);
		logic [7:0]  seq[$];
		int unsigned n_chars;
		int unsigned kind;
		int unsigned cut;
		n_chars = $urandom_range(1, 6);
		repeat (n_chars) begin
			kind = $urandom_range(0, 19);
			if (kind < 9) begin
				seq.push_back(($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
			end else if (kind < 13) begin
				seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
				seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end else if (kind < 18) begin
				seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
				seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
				seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end else begin
				seq.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (m) begin
			if ($urandom_range(0, 9) != 0)
				seq.push_back(8'h00);
			foreach (seq[i])
				send_octet(seq[i], 1'($urandom_range(0, 1)));
		end else begin
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seq.size()) : seq.size();
			for (int unsigned i = 0; i < cut; i++)
				send_octet(seq[i], (i == cut - 1) || ($urandom_range(0, 39) == 0));
		end
	endtask

	task automatic test_random_streams();
		int unsigned phase_end;
		logic        m;
		for (int p = 0; p < 6; p++) begin
			m = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
			set_mode(m);
			idle_en   = ($urandom_range(0, 4) != 0);
			stall_en  = ($urandom_range(0, 4) != 0);
			phase_end = octets_sent + 275;
			while (octets_sent < phase_end)
				send_random_string(m);
		end
		byte_bus.valid <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (result_bus.char_ready !== want.char_ready)
					report_mismatch($sformatf("char_ready got %b want %b",
						result_bus.char_ready, want.char_ready));
				if (result_bus.code_point !== want.code_point)
					report_mismatch($sformatf("code_point got %h want %h",
						result_bus.code_point, want.code_point));
				if (result_bus.string_done !== want.string_done)
					report_mismatch($sformatf("string_done got %b want %b",
						result_bus.string_done, want.string_done));
				if (result_bus.error_code !== want.error_code)
					report_mismatch($sformatf("error_code got %0d want %0d",
						result_bus.error_code, want.error_code));
				if (result_bus.octet_count !== want.octet_count)
					report_mismatch($sformatf("octet_count got %0d want %0d",
						result_bus.octet_count, want.octet_count));
				if (result_bus.char_count !== want.char_count)
					report_mismatch($sformatf("char_count got %0d want %0d",
						result_bus.char_count, want.char_count));
				if (result_bus.has_embedded_nul !== want.has_embedded_nul)
					report_mismatch($sformatf("has_embedded_nul got %b want %b",
						result_bus.has_embedded_nul, want.has_embedded_nul));
			end
		end
	end

	initial begin : result_sink
		int unsigned stall;
		result_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			result_bus.ready <= 1'b1;
			if (!stall_en) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 20)) @(posedge clk);
				stall = pick_gap();
				if (stall != 0) begin
					result_bus.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		#(20_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n                 <= 1'b0;
		cfg_bus.valid          <= 1'b0;
		cfg_bus.nul_terminated <= 1'b0;
		byte_bus.valid         <= 1'b0;
		byte_bus.data_byte     <= 8'h00;
		byte_bus.end_of_string <= 1'b0;
		nul_mode = 1'b0;
		clear_stream();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_delimited_forms();
		test_nul_terminated_forms();
		test_random_streams();

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
